// ===== src/multiturn_position_tracker_top_macros.svh =====
// Assertion macros used by the checker in mtpt_checker.sv.
`ifndef MULTITURN_POSITION_TRACKER_TOP_MACROS_SVH
`define MULTITURN_POSITION_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define MTPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtpt assertion failed");

// Next-cycle implication, masked during reset.
`define MTPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtpt assertion failed");

// Next-cycle implication that also checks the reset itself.
`define MTPT_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mtpt assertion failed");

`endif

// ===== src/mtpt_pkg.sv =====
package mtpt_pkg;

    localparam int ANGLE_W   = 32;
    localparam int ACC_W     = 64;
    localparam int TURN_W    = 32;
    localparam int DIVISOR_W = 16;
    localparam int COUNT_LSB = 8;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // serial remainder: one dividend bit per cycle
    localparam int MOD_STEPS = TURN_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // serial subtractor: one digit per cycle
    localparam int SUB_DIGIT = 8;
    localparam int SUB_STEPS = ACC_W / SUB_DIGIT;
    localparam int SUB_CNT_W = $clog2(SUB_STEPS);

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== src/mtpt_mod_serial.sv =====
module mtpt_mod_serial (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [mtpt_pkg::TURN_W-1:0]      i_dividend,
    input  logic [mtpt_pkg::DIVISOR_W-1:0]   i_divisor,
    output mtpt_pkg::t_unit_stat             o_stat,
    output logic [mtpt_pkg::DIVISOR_W-1:0]   o_rem
);

    logic                              r_busy;
    logic                              r_done;
    logic [mtpt_pkg::MOD_CNT_W-1:0]    r_cnt;
    logic [mtpt_pkg::TURN_W-1:0]       r_dvd;
    logic [mtpt_pkg::DIVISOR_W-1:0]    r_div;
    logic [mtpt_pkg::DIVISOR_W-1:0]    r_rem;
    logic [mtpt_pkg::DIVISOR_W:0]      trial;
    logic [mtpt_pkg::DIVISOR_W-1:0]    n_rem;

    // restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[mtpt_pkg::TURN_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = mtpt_pkg::DIVISOR_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[mtpt_pkg::DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mtpt_pkg::MOD_CNT_W'(mtpt_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= (i_divisor == '0) ? mtpt_pkg::DIVISOR_W'(1) : i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[mtpt_pkg::TURN_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// ===== src/mtpt_sub_serial.sv =====
module mtpt_sub_serial (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mtpt_pkg::ACC_W-1:0]    i_a,
    input  logic [mtpt_pkg::ACC_W-1:0]    i_b,
    output mtpt_pkg::t_unit_stat          o_stat,
    output logic [mtpt_pkg::ACC_W-1:0]    o_diff
);

    logic                              r_busy;
    logic                              r_done;
    logic [mtpt_pkg::SUB_CNT_W-1:0]    r_cnt;
    logic [mtpt_pkg::ACC_W-1:0]        r_a;
    logic [mtpt_pkg::ACC_W-1:0]        r_b;
    logic [mtpt_pkg::ACC_W-1:0]        r_diff;
    logic                              r_carry;
    logic [mtpt_pkg::SUB_DIGIT:0]      digit_sum;

    // a - b as a + ~b + 1, low digit first
    always_comb begin
        digit_sum = {1'b0, r_a[mtpt_pkg::SUB_DIGIT-1:0]}
                  + {1'b0, ~r_b[mtpt_pkg::SUB_DIGIT-1:0]}
                  + (mtpt_pkg::SUB_DIGIT+1)'(r_carry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mtpt_pkg::SUB_CNT_W'(mtpt_pkg::SUB_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_carry <= 1'b1;
        end else if (r_busy) begin
            r_a     <= r_a >> mtpt_pkg::SUB_DIGIT;
            r_b     <= r_b >> mtpt_pkg::SUB_DIGIT;
            r_carry <= digit_sum[mtpt_pkg::SUB_DIGIT];
            r_diff  <= {digit_sum[mtpt_pkg::SUB_DIGIT-1:0],
                        r_diff[mtpt_pkg::ACC_W-1:mtpt_pkg::SUB_DIGIT]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_diff      = r_diff;

endmodule

// ===== src/multiturn_position_tracker_top.sv =====
// Flow: a sample without an armed wrap goes IDLE, LATCH, SUB (serial subtract), DONE;
//   an armed wrap first runs the 32-step serial remainder of the turn count in MOD.
// Throughput: one sample at a time; the remainder unit (one bit per cycle) and the
//   8-digit serial subtractor set the pace. A finished result may wait
//   in the output register while the next sample is taken.
// Reset: synchronous, active low; clears all tracking state, divisor returns to 1.
module multiturn_position_tracker_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mtpt_pkg::DIVISOR_W-1:0]       i_cfg_wr_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mtpt_pkg::ANGLE_W-1:0]         i_angle_word,
    input  logic                                 i_zero_request,
    input  logic                                 i_arm_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [31:0]                   o_raw_count,
    output logic signed [31:0]                   o_relative_count,
    output logic signed [mtpt_pkg::ACC_W-1:0]    o_relative_position,
    output logic                                 o_index_still_armed
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_LATCH = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic [mtpt_pkg::DIVISOR_W-1:0]      r_divisor;
    logic [mtpt_pkg::ACC_W-1:0]          r_acc;
    logic [mtpt_pkg::ACC_W-1:0]          n_acc;
    logic [mtpt_pkg::ANGLE_W-1:0]        r_prev;
    logic [mtpt_pkg::TURN_W-1:0]         r_turn;
    logic [mtpt_pkg::TURN_W-1:0]         n_turn;
    logic [mtpt_pkg::ACC_W-1:0]          r_offset;
    logic [mtpt_pkg::ACC_W-1:0]          n_offset;
    logic                                r_armed;
    logic                                n_armed;
    logic                                r_fwd;
    logic                                r_checked;
    logic                                r_zero_req;
    logic [mtpt_pkg::ANGLE_W-1:0]        r_word;

    logic                                r_out_valid;
    logic [31:0]                         r_raw;
    logic [mtpt_pkg::ACC_W-1:0]          r_rel;
    logic                                r_out_armed;

    logic                                in_fire;
    logic [mtpt_pkg::ANGLE_W-1:0]        delta;
    logic                                wrap_fwd;
    logic                                wrap_bwd;
    logic                                armed_in;
    logic                                mod_start;
    logic                                sub_start;
    logic                                match;
    logic                                div_is_one;
    logic                                out_free;
    logic [mtpt_pkg::ACC_W-1:0]          latch_sub;

    mtpt_pkg::t_unit_stat                mod_stat;
    mtpt_pkg::t_unit_stat                sub_stat;
    logic [mtpt_pkg::DIVISOR_W-1:0]      mod_rem;
    logic [mtpt_pkg::ACC_W-1:0]          sub_diff;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign delta    = i_angle_word - r_prev;
    assign wrap_fwd = (r_prev > i_angle_word)
                   && ((r_prev - i_angle_word) > mtpt_pkg::HALF_TURN);
    assign wrap_bwd = (i_angle_word > r_prev)
                   && ((i_angle_word - r_prev) > mtpt_pkg::HALF_TURN);
    assign armed_in = r_armed || i_arm_index;

    assign div_is_one = (r_divisor == mtpt_pkg::DIVISOR_W'(1)) || (r_divisor == '0);
    assign match = r_checked
                && (r_fwd ? (div_is_one || (mod_rem == mtpt_pkg::DIVISOR_W'(1)))
                          : (mod_rem == '0));
    // backward latch adds one turn: subtract (word - 2^32) instead of word
    assign latch_sub = r_fwd ? {{(mtpt_pkg::ACC_W-mtpt_pkg::ANGLE_W){1'b0}}, r_word}
                             : {{(mtpt_pkg::ACC_W-mtpt_pkg::ANGLE_W){1'b1}}, r_word};

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_turn    = r_turn;
        n_offset  = r_offset;
        n_armed   = r_armed;
        mod_start = 1'b0;
        sub_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_acc   = r_acc + {{(mtpt_pkg::ACC_W-mtpt_pkg::ANGLE_W)
                                       {delta[mtpt_pkg::ANGLE_W-1]}}, delta};
                    n_armed = armed_in;
                    if (wrap_fwd) begin
                        n_turn = r_turn + 1'b1;
                    end else if (wrap_bwd) begin
                        n_turn = r_turn - 1'b1;
                    end
                    if ((wrap_fwd || wrap_bwd) && armed_in) begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end else begin
                        n_state = S_LATCH;
                    end
                end
            end
            S_MOD: begin
                if (mod_stat.done) begin
                    n_state = S_LATCH;
                end
            end
            S_LATCH: begin
                if (match) begin
                    n_offset = r_acc - latch_sub;
                    n_armed  = 1'b0;
                end
                // zero request overrides an index latch
                if (r_zero_req) begin
                    n_offset = r_acc;
                end
                sub_start = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                if (sub_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_divisor   <= mtpt_pkg::DIVISOR_W'(1);
            r_acc       <= '0;
            r_prev      <= '0;
            r_turn      <= '0;
            r_offset    <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_turn   <= n_turn;
            r_offset <= n_offset;
            r_armed  <= n_armed;
            if (i_cfg_wr_en) begin
                r_divisor <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_prev <= i_angle_word;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-sample scratch and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word     <= i_angle_word;
            r_zero_req <= i_zero_request;
            r_fwd      <= wrap_fwd;
            r_checked  <= (wrap_fwd || wrap_bwd) && armed_in;
        end
        if (r_state == S_DONE && out_free) begin
            r_raw       <= r_acc[mtpt_pkg::COUNT_LSB+31:mtpt_pkg::COUNT_LSB];
            r_rel       <= sub_diff;
            r_out_armed <= r_armed;
        end
    end

    mtpt_mod_serial u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (n_turn),
        .i_divisor  (r_divisor),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    mtpt_sub_serial u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sub_start),
        .i_a     (r_acc),
        .i_b     (n_offset),
        .o_stat  (sub_stat),
        .o_diff  (sub_diff)
    );

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_raw_count         = r_raw;
    assign o_relative_count    = r_rel[mtpt_pkg::COUNT_LSB+31:mtpt_pkg::COUNT_LSB];
    assign o_relative_position = r_rel;
    assign o_index_still_armed = r_out_armed;

endmodule

// ===== src/mtpt_checker.sv =====
`include "multiturn_position_tracker_top_macros.svh"

module mtpt_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [31:0]                   o_raw_count,
    input logic signed [31:0]                   o_relative_count,
    input logic signed [mtpt_pkg::ACC_W-1:0]    o_relative_position
);

    // hold a result until its transaction completes
    `MTPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_relative_position) && $stable(o_raw_count))

    // relative count is a slice of the relative position
    `MTPT_ASSERT_NOW(a_rel_slice, i_clk, i_rst_n, o_out_valid,
        o_relative_count == o_relative_position[39:8])

    // one sample in flight: drop ready right after a transaction
    `MTPT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready)

    // reset leaves the block empty and ready
    `MTPT_ASSERT_RST(a_reset_state, i_clk, !i_rst_n, o_in_ready && !o_out_valid)

endmodule

bind multiturn_position_tracker_top mtpt_checker u_mtpt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_raw_count         (o_raw_count),
    .o_relative_count    (o_relative_count),
    .o_relative_position (o_relative_position)
);

// ===== tb/multiturn_position_tracker_top_tb.sv =====
`timescale 1ns / 1ps

module multiturn_position_tracker_top_tb;

    typedef struct packed {
        logic signed [31:0]                raw_count;
        logic signed [31:0]                relative_count;
        logic signed [mtpt_pkg::ACC_W-1:0] relative_position;
        logic                              still_armed;
    } t_position_sample;

    typedef struct packed {
        logic [mtpt_pkg::ANGLE_W-1:0] word;
        logic                         zero_req;
        logic                         arm;
    } t_angle_sample;

    typedef enum int {
        MOTION_ROTATE, MOTION_NOISE, MOTION_HALF_TURN, MOTION_CORNERS
    } t_motion;

    localparam logic [mtpt_pkg::ANGLE_W-1:0] CORNER_WORDS [5] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001
    };

    // exact half turns, wraps both ways, latch under zero request, arm held high
    localparam t_angle_sample DIRECTED_SAMPLES [15] = '{
        '{32'h0000_0000, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1},
        '{32'h7FFF_FFFF, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b1},
        '{32'h8000_0000, 1'b1, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b1},
        '{32'hC000_0000, 1'b0, 1'b0},
        '{32'h4000_0000, 1'b1, 1'b1},
        '{32'hF000_0000, 1'b1, 1'b1},
        '{32'h1000_0000, 1'b0, 1'b1},
        '{32'h9000_0001, 1'b0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b1}
    };

    class t_position_scoreboard;
        logic [mtpt_pkg::DIVISOR_W-1:0] divisor;
        logic [mtpt_pkg::ACC_W-1:0]     accum;
        logic [mtpt_pkg::ANGLE_W-1:0]   last_word;
        logic [mtpt_pkg::TURN_W-1:0]    turns;
        logic [mtpt_pkg::ACC_W-1:0]     offset;
        logic                           armed;
        t_position_sample               pending_q[$];
        int                             errors;

        function new();
            divisor   = mtpt_pkg::DIVISOR_W'(1);
            accum     = '0;
            last_word = '0;
            turns     = '0;
            offset    = '0;
            armed     = 1'b0;
            errors    = 0;
        endfunction

        function void note_sample(logic [mtpt_pkg::ANGLE_W-1:0] word, logic zero_req,
                                  logic arm);
            logic [mtpt_pkg::TURN_W-1:0]  div;
            logic [mtpt_pkg::ANGLE_W-1:0] step;
            logic [mtpt_pkg::ANGLE_W-1:0] drop;
            logic [mtpt_pkg::ACC_W-1:0]   rel;
            t_position_sample             want;
            div  = (divisor == '0) ? mtpt_pkg::TURN_W'(1) : mtpt_pkg::TURN_W'(divisor);
            step = word - last_word;
            drop = last_word - word;
            if (arm)
                armed = 1'b1;
            accum = accum + {{(mtpt_pkg::ACC_W-mtpt_pkg::ANGLE_W){step[mtpt_pkg::ANGLE_W-1]}},
                             step};
            if (last_word > word && drop > mtpt_pkg::HALF_TURN) begin
                turns = turns + 1'b1;
                if (armed && (div == 1 || turns % div == 1)) begin
                    offset = accum - mtpt_pkg::ACC_W'(word);
                    armed  = 1'b0;
                end
            end else if (last_word < word && step > mtpt_pkg::HALF_TURN) begin
                turns = turns - 1'b1;
                if (armed && turns % div == 0) begin
                    offset = accum - mtpt_pkg::ACC_W'(word) + 64'h1_0000_0000;
                    armed  = 1'b0;
                end
            end
            // zero request overrides an index latch in the same sample
            if (zero_req)
                offset = accum;
            last_word = word;
            rel = accum - offset;
            want.raw_count         = accum[mtpt_pkg::COUNT_LSB +: 32];
            want.relative_count    = rel[mtpt_pkg::COUNT_LSB +: 32];
            want.relative_position = rel;
            want.still_armed       = armed;
            pending_q.push_back(want);
        endfunction

        function void check_result(t_position_sample got);
            t_position_sample want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with no sample pending: %s %h %h %h %b",
                             "raw/rel/pos/armed", got.raw_count, got.relative_count,
                             got.relative_position, got.still_armed);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp/got raw %h/%h rel %h/%h pos %h/%h armed %b/%b",
                             want.raw_count, got.raw_count,
                             want.relative_count, got.relative_count,
                             want.relative_position, got.relative_position,
                             want.still_armed, got.still_armed);
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_wr_en;
    logic [mtpt_pkg::DIVISOR_W-1:0]    i_cfg_wr_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [mtpt_pkg::ANGLE_W-1:0]      i_angle_word;
    logic                              i_zero_request;
    logic                              i_arm_index;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic signed [31:0]                o_raw_count;
    logic signed [31:0]                o_relative_count;
    logic signed [mtpt_pkg::ACC_W-1:0] o_relative_position;
    logic                              o_index_still_armed;

    t_position_scoreboard          tracker;
    logic [mtpt_pkg::ANGLE_W-1:0]  gen_word;

    always #5 i_clk = ~i_clk;

    multiturn_position_tracker_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_angle_word        (i_angle_word),
        .i_zero_request      (i_zero_request),
        .i_arm_index         (i_arm_index),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_raw_count         (o_raw_count),
        .o_relative_count    (o_relative_count),
        .o_relative_position (o_relative_position),
        .o_index_still_armed (o_index_still_armed)
    );

    // Valid stays high after a transaction unless a gap follows.
    task automatic send_sample(input logic [mtpt_pkg::ANGLE_W-1:0] word,
                               input logic zero_req, input logic arm);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_angle_word   <= word;
        i_zero_request <= zero_req;
        i_arm_index    <= arm;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_sample(word, zero_req, arm);
        gen_word = word;
    endtask

    task automatic write_divisor(input logic [mtpt_pkg::DIVISOR_W-1:0] value);
        i_in_valid <= 1'b0;
        while (tracker.pending_q.size() != 0)
            @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.divisor = value;
    endtask

    task automatic run_phase(input int n_items);
        int                           sent;
        int                           burst;
        int                           pick;
        t_motion                      motion;
        logic [mtpt_pkg::ANGLE_W-1:0] speed;
        logic [mtpt_pkg::ANGLE_W-1:0] word;
        sent = 0;
        while (sent < n_items) begin
            burst   = $urandom_range(4, 40);
            pick    = $urandom_range(0, 9);
            motion  = (pick < 6) ? MOTION_ROTATE : (pick < 8) ? MOTION_NOISE :
                      (pick == 8) ? MOTION_HALF_TURN : MOTION_CORNERS;
            case ($urandom_range(0, 2))
                0: speed = $urandom_range(0, 32'h0100_0000);
                1: speed = $urandom_range(32'h6000_0000, 32'h7FFF_FFFF);
                default: speed = $urandom & 32'h7FFF_FFFF;
            endcase
            if ($urandom_range(0, 1))
                speed = -speed;
            repeat (burst) begin
                case (motion)
                    MOTION_ROTATE:    word = gen_word + speed + $urandom_range(0, 255) - 128;
                    MOTION_NOISE:     word = $urandom;
                    MOTION_HALF_TURN: word = gen_word + mtpt_pkg::HALF_TURN
                                             + $urandom_range(0, 2) - 1;
                    default:          word = CORNER_WORDS[$urandom_range(0, 4)];
                endcase
                send_sample(word, $urandom_range(0, 15) == 0, $urandom_range(0, 3) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        logic [mtpt_pkg::DIVISOR_W-1:0] divisors [10];
        tracker = new();
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_in_valid     <= 1'b0;
        i_angle_word   <= '0;
        i_zero_request <= 1'b0;
        i_arm_index    <= 1'b0;
        gen_word = '0;
        divisors = '{16'd2, 16'd0, 16'hFFFF, 16'd3, 16'd1, 16'd4, 16'h8000, 16'd0, 16'd0, 16'd5};
        divisors[7] = mtpt_pkg::DIVISOR_W'($urandom_range(1, 65535));
        divisors[8] = mtpt_pkg::DIVISOR_W'($urandom_range(2, 9));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_SAMPLES[i])
            send_sample(DIRECTED_SAMPLES[i].word, DIRECTED_SAMPLES[i].zero_req,
                        DIRECTED_SAMPLES[i].arm);

        foreach (divisors[i]) begin
            write_divisor(divisors[i]);
            run_phase(180);
        end

        i_in_valid <= 1'b0;
        while (tracker.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: stall ready per transaction, check on every accepted result.
    initial begin
        int               stall;
        t_position_sample got;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.raw_count         = o_raw_count;
            got.relative_count    = o_relative_count;
            got.relative_position = o_relative_position;
            got.still_armed       = o_index_still_armed;
            tracker.check_result(got);
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
